>>> rtl/core/lcdsw_pkg.sv
// Shared types and constants for the LCD shadow pixel writer.
`default_nettype none

package lcdsw_pkg;

    // One pixel request: set or clear the pixel at (x_column, y_row)
    typedef struct packed {
        logic       operation;
        logic [7:0] x_column;
        logic [6:0] y_row;
    } t_pixel_req;

    // One byte toward the LCD controller
    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       is_data;
        logic       last;
    } t_lcd_out;

    // Strobes from the sequencer to the shadow memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    // Pixel operation codes
    localparam logic OP_SET   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Controller command bytes
    localparam logic [7:0] CMD_PAGE         = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW_MASK = 8'h0F;
    localparam logic [7:0] CMD_COL_HIGH     = 8'h10;
    localparam logic [7:0] PIXEL_ONE        = 8'h01;

    // Position within the four-byte run
    localparam logic [1:0] BYTE_PAGE     = 2'd0;
    localparam logic [1:0] BYTE_COL_LOW  = 2'd1;
    localparam logic [1:0] BYTE_COL_HIGH = 2'd2;
    localparam logic [1:0] BYTE_DATA     = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/lcd_shadow_pixel_writer.sv
// Top level of the LCD shadow pixel writer.
//
// Keeps a shadow of a page-addressed monochrome LCD in one synchronous
// memory and turns set/clear pixel transactions into controller bytes.
// After reset the block runs a clearing pass over every shadow address
// with o_in_ready low. It then works on one transaction at a time: accept
// and read the shadow byte, then, if the pixel changes, four output
// transactions (set-page, column-low, column-high, data with last set),
// one per cycle while i_out_ready is high. A pixel that does not change
// or lies off the panel sends no bytes. No new pixel is taken until the
// block is done with the last one.
`default_nettype none

module lcd_shadow_pixel_writer
    import lcdsw_pkg::*;
#(
    parameter int PAGE_COUNT   = 16,
    parameter int COLUMN_COUNT = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_pixel_req i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_lcd_out        o_out_data
);

    localparam int PAW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CAW = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam int AW  = PAW + CAW;

    t_mem_ctl      mem_ctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    rd_data;

    // Sequencer
    lcdsw_seq #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_mem_ctl   (mem_ctl),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_rd_data   (rd_data)
    );

    // Shadow memory
    lcdsw_store #(
        .ADDR_WIDTH (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/lcdsw_store.sv
// Shadow memory: one write port, one read port with registered read data.
`default_nettype none

module lcdsw_store
    import lcdsw_pkg::*;
#(
    parameter int ADDR_WIDTH = 12
) (
    input  wire logic                  i_clk,
    input  wire t_mem_ctl              i_ctl,
    input  wire logic [ADDR_WIDTH-1:0] i_rd_addr,
    input  wire logic [ADDR_WIDTH-1:0] i_wr_addr,
    input  wire logic [7:0]            i_wr_data,
    output logic      [7:0]            o_rd_data
);

    localparam int DEPTH = 1 << ADDR_WIDTH;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/core/lcdsw_seq.sv
// Sequencer: clearing pass, read-modify-write of a shadow byte, four-byte emit.
`default_nettype none

module lcdsw_seq
    import lcdsw_pkg::*;
#(
    parameter int PAGE_COUNT   = 16,
    parameter int COLUMN_COUNT = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_pixel_req i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_lcd_out        o_out_data,
    output t_mem_ctl        o_mem_ctl,
    output logic [((PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1)
                 + ((COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1) - 1:0] o_rd_addr,
    output logic [((PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1)
                 + ((COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1) - 1:0] o_wr_addr,
    output logic [7:0]      o_wr_data,
    input  wire logic [7:0] i_rd_data
);

    localparam int PAW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CAW = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam int AW  = PAW + CAW;

    localparam logic [4:0] PAGE_LIM = 5'(PAGE_COUNT);
    localparam logic [8:0] COL_LIM  = 9'(COLUMN_COUNT);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // Control state
    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [1:0]    r_cnt, n_cnt;

    // Latched transaction and new byte
    logic          r_op;
    logic [3:0]    r_page;
    logic [7:0]    r_col;
    logic [2:0]    r_bit;
    logic [AW-1:0] r_addr;
    logic [7:0]    r_byte;

    logic          in_fire;
    logic          out_fire;
    logic          in_range;
    logic [AW-1:0] in_addr;
    logic [7:0]    bit_mask;
    logic          bit_hit;
    logic          changes;
    logic [7:0]    new_byte;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    // Range check and memory address of the incoming pixel
    assign in_range = ({1'b0, i_in_data.y_row[6:3]} < PAGE_LIM)
                   && ({1'b0, i_in_data.x_column} < COL_LIM);
    assign in_addr  = {i_in_data.y_row[3 +: PAW], i_in_data.x_column[CAW-1:0]};

    // Modify the byte read back from the store
    assign bit_mask = PIXEL_ONE << r_bit;
    assign bit_hit  = |(i_rd_data & bit_mask);
    assign changes  = (r_op == OP_CLEAR) ? bit_hit : !bit_hit;
    assign new_byte = (r_op == OP_CLEAR) ? (i_rd_data & ~bit_mask)
                                         : (i_rd_data | bit_mask);

    // Memory strobes and addresses
    always_comb begin
        o_mem_ctl.rd_en = (r_state == ST_IDLE) && i_in_valid;
        o_mem_ctl.wr_en = (r_state == ST_CLEAR) || ((r_state == ST_READ) && changes);
        o_rd_addr       = in_addr;
        o_wr_addr       = (r_state == ST_CLEAR) ? r_clr_addr : r_addr;
        o_wr_data       = (r_state == ST_CLEAR) ? 8'h00 : new_byte;
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cnt      = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire && in_range) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_cnt   = BYTE_PAGE;
                n_state = changes ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_fire) begin
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == BYTE_DATA) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_cnt      <= BYTE_PAGE;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_cnt      <= n_cnt;
        end
    end

    // Hold the accepted transaction and the updated byte
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= i_in_data.operation;
            r_page <= i_in_data.y_row[6:3];
            r_col  <= i_in_data.x_column;
            r_bit  <= i_in_data.y_row[2:0];
            r_addr <= in_addr;
        end
        if (r_state == ST_READ) begin
            r_byte <= new_byte;
        end
    end

    // Handshake and output byte
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);

    always_comb begin
        o_out_data.is_data = 1'b0;
        o_out_data.last    = 1'b0;
        case (r_cnt)
            BYTE_PAGE:     o_out_data.lcd_byte = CMD_PAGE | {4'h0, r_page};
            BYTE_COL_LOW:  o_out_data.lcd_byte = r_col & CMD_COL_LOW_MASK;
            BYTE_COL_HIGH: o_out_data.lcd_byte = CMD_COL_HIGH | {4'h0, r_col[7:4]};
            BYTE_DATA: begin
                o_out_data.lcd_byte = r_byte;
                o_out_data.is_data  = 1'b1;
                o_out_data.last     = 1'b1;
            end
            default:       o_out_data.lcd_byte = r_byte;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/lcdsw_checker.sv
// Port-level checker for the LCD shadow pixel writer, with its bind.
`default_nettype none

module lcdsw_checker
    import lcdsw_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire t_pixel_req i_in_data,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire t_lcd_out   o_out_data
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

    // Never take a new pixel while a run is being sent
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted during output run");

    // Only the data byte closes a run
    a_data_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_data == o_out_data.last))
        else $error("data flag and last flag disagree");

    // Keep a run going until its last byte
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last |=> o_out_valid)
        else $error("output run broke off before its last byte");

    // Drop valid once the last byte has gone
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last |=> !o_out_valid)
        else $error("output continued after last byte");

endmodule

bind lcd_shadow_pixel_writer lcdsw_checker u_lcdsw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
